// ===== design/nlp_pkg.sv =====
// package for the number literal parser: phase codes, characters and scale constants
package nlp_pkg;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_SIGNED = 4'd1,
      PH_ZERO   = 4'd2,
      PH_OCT    = 4'd3,
      PH_HEX    = 4'd4,
      PH_DEC    = 4'd5,
      PH_SUFFIX = 4'd6,
      PH_DONE   = 4'd7,
      PH_SKIP   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      SFX_NONE = 2'd0,
      SFX_K    = 2'd1,
      SFX_M    = 2'd2,
      SFX_G    = 2'd3
   } suffix_type;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_K  = 8'h6B;
   localparam logic [7:0] CH_UP_K  = 8'h4B;
   localparam logic [7:0] CH_LO_M  = 8'h6D;
   localparam logic [7:0] CH_UP_M  = 8'h4D;
   localparam logic [7:0] CH_LO_G  = 8'h67;
   localparam logic [7:0] CH_UP_G  = 8'h47;
   localparam logic [7:0] CH_LO_B  = 8'h62;
   localparam logic [7:0] CH_UP_B  = 8'h42;

   localparam int unsigned ACC_W   = 64;
   localparam int unsigned SCALE_W = 30;

   localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

   // decimal multipliers for none, k, m, g
   localparam logic [SCALE_W-1:0] DEC_SCALE [4] = '{
      30'd1, 30'd1000, 30'd1000000, 30'd1000000000
   };

   // largest accumulator that survives the decimal scaling
   localparam logic [ACC_W-1:0] DEC_LIMIT [4] = '{
      ACC_MAX,
      ACC_MAX / 64'd1000,
      ACC_MAX / 64'd1000000,
      ACC_MAX / 64'd1000000000
   };

endpackage

// ===== design/number_literal_parser_with_size_suffix_unit.sv =====
// Number literal parser: takes one ASCII character per item and, at the zero byte, returns
// the signed 64-bit value with malformed and wrapped flags. Accepts an optional sign, then
// 0x/0X hex, leading-0 octal or decimal digits, and an optional k/m/g suffix where a
// following b scales by a power of ten and B or the terminator by a power of two. One item
// per cycle sustained while no result is stalled; a character goes through an input register,
// one pass of update logic (a 32x30 multiplier pair for the decimal suffix scaling is the
// longest path) and lands in the result register. Only the terminator produces a result item.
module number_literal_parser_with_size_suffix_unit
   import nlp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_ch,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [63:0]  rsp_value,
   output logic                rsp_malformed,
   output logic                rsp_wrapped
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;

   // parse state
   phase_type        phase_ff, phase_in;
   logic             neg_ff, neg_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   suffix_type       sfx_ff, sfx_in;
   logic             err_ff, err_in;
   logic             wrap_ff, wrap_in;

   // result register
   logic             out_valid_ff, out_valid_in;
   logic [ACC_W-1:0] out_value_ff, out_value_in;
   logic             out_err_ff, out_err_in;
   logic             out_wrap_ff, out_wrap_in;

   logic       advance;
   logic       emit;
   logic [7:0] ch;

   // character classes
   logic       is_oct, is_dec, is_hex, is_sign;
   logic [3:0] hex_val;
   suffix_type ch_sfx;

   // candidate accumulator updates
   logic [ACC_W-1:0] oct_acc, hex_acc, first_acc, bin_acc, dsc_acc;
   logic             oct_wrap, hex_wrap, bin_wrap, dsc_wrap;
   logic [ACC_W+3:0] dec_sum;
   logic [SCALE_W-1:0] dec_m;
   logic [61:0]      dsc_lo;
   logic [31:0]      dsc_hi;

   assign ch        = in_ch_ff;
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      is_oct  = ch inside {[8'h30:8'h37]};
      is_dec  = ch inside {[8'h30:8'h39]};
      is_hex  = is_dec || (ch inside {[8'h41:8'h46], [8'h61:8'h66]});
      is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
      hex_val = is_dec ? ch[3:0] : 4'(ch[3:0] + 4'd9);
      case (ch)
         CH_LO_K, CH_UP_K: ch_sfx = SFX_K;
         CH_LO_M, CH_UP_M: ch_sfx = SFX_M;
         CH_LO_G, CH_UP_G: ch_sfx = SFX_G;
         default:          ch_sfx = SFX_NONE;
      endcase
   end

   // digit and scale arithmetic, all candidates built in parallel
   always_comb begin
      oct_acc  = {acc_ff[ACC_W-4:0], ch[2:0]};
      oct_wrap = |acc_ff[ACC_W-1:ACC_W-3];
      hex_acc  = {acc_ff[ACC_W-5:0], hex_val};
      hex_wrap = |acc_ff[ACC_W-1:ACC_W-4];
      first_acc = {{(ACC_W-4){1'b0}}, ch[3:0]};
      // times ten as two shifts
      dec_sum  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
               + {{(ACC_W){1'b0}}, ch[3:0]};
      case (sfx_ff)
         SFX_K:   begin bin_acc = {acc_ff[ACC_W-11:0], 10'd0}; bin_wrap = |acc_ff[63:54]; end
         SFX_M:   begin bin_acc = {acc_ff[ACC_W-21:0], 20'd0}; bin_wrap = |acc_ff[63:44]; end
         SFX_G:   begin bin_acc = {acc_ff[ACC_W-31:0], 30'd0}; bin_wrap = |acc_ff[63:34]; end
         default: begin bin_acc = acc_ff; bin_wrap = 1'b0; end
      endcase
      dec_m    = DEC_SCALE[sfx_ff];
      dsc_lo   = 62'(acc_ff[31:0]) * 62'(dec_m);
      dsc_hi   = acc_ff[63:32] * 32'(dec_m);
      dsc_acc  = 64'(dsc_lo) + {dsc_hi, 32'd0};
      dsc_wrap = acc_ff > DEC_LIMIT[sfx_ff];
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         case (phase_ff)
            PH_START, PH_SIGNED: begin
               if (phase_ff == PH_START && is_sign) phase_in = PH_SIGNED;
               else if (ch == CH_NUL)               phase_in = PH_START;
               else if (ch == CH_ZERO)              phase_in = PH_ZERO;
               else if (is_dec)                     phase_in = PH_DEC;
               else                                 phase_in = PH_SKIP;
            end
            PH_ZERO, PH_OCT, PH_HEX, PH_DEC: begin
               if (phase_ff == PH_ZERO && (ch == CH_LO_X || ch == CH_UP_X))
                  phase_in = PH_HEX;
               else if ((phase_ff == PH_ZERO || phase_ff == PH_OCT) && is_oct)
                  phase_in = PH_OCT;
               else if ((phase_ff == PH_HEX && is_hex) || (phase_ff == PH_DEC && is_dec))
                  phase_in = phase_ff;
               else if (ch == CH_NUL)      phase_in = PH_START;
               else if (ch_sfx != SFX_NONE) phase_in = PH_SUFFIX;
               else                        phase_in = PH_SKIP;
            end
            PH_SUFFIX: begin
               if (ch == CH_LO_B || ch == CH_UP_B) phase_in = PH_DONE;
               else if (ch == CH_NUL)              phase_in = PH_START;
               else                                phase_in = PH_SKIP;
            end
            default: begin
               if (ch == CH_NUL) phase_in = PH_START;
            end
         endcase
      end
   end

   // datapath updates and result
   always_comb begin
      logic             n_neg, n_err, n_wrap;
      logic [ACC_W-1:0] n_acc;
      suffix_type       n_sfx;
      n_neg  = neg_ff;
      n_acc  = acc_ff;
      n_sfx  = sfx_ff;
      n_err  = err_ff;
      n_wrap = wrap_ff;
      emit   = 1'b0;
      case (phase_ff)
         PH_START, PH_SIGNED: begin
            if (phase_ff == PH_START && is_sign) begin
               n_neg = (ch == CH_MINUS);
            end else if (ch == CH_NUL) begin
               n_err = 1'b1;
               emit  = 1'b1;
            end else if (is_dec && ch != CH_ZERO) begin
               n_acc = first_acc;
            end else if (ch != CH_ZERO) begin
               n_err = 1'b1;
            end
         end
         PH_ZERO, PH_OCT, PH_HEX, PH_DEC: begin
            if (phase_ff == PH_ZERO && (ch == CH_LO_X || ch == CH_UP_X)) begin
               n_acc = acc_ff;
            end else if ((phase_ff == PH_ZERO || phase_ff == PH_OCT) && is_oct) begin
               n_acc  = oct_acc;
               n_wrap = wrap_ff | oct_wrap;
            end else if (phase_ff == PH_HEX && is_hex) begin
               n_acc  = hex_acc;
               n_wrap = wrap_ff | hex_wrap;
            end else if (phase_ff == PH_DEC && is_dec) begin
               n_acc  = dec_sum[ACC_W-1:0];
               n_wrap = wrap_ff | (|dec_sum[ACC_W+3:ACC_W]);
            end else if (ch == CH_NUL) begin
               emit = 1'b1;
            end else if (ch_sfx != SFX_NONE) begin
               n_sfx = ch_sfx;
            end else begin
               n_err = 1'b1;
            end
         end
         PH_SUFFIX: begin
            if (ch == CH_LO_B) begin
               n_acc  = dsc_acc;
               n_wrap = wrap_ff | dsc_wrap;
            end else if (ch == CH_UP_B || ch == CH_NUL) begin
               n_acc  = bin_acc;
               n_wrap = wrap_ff | bin_wrap;
               emit   = (ch == CH_NUL);
            end else begin
               n_err = 1'b1;
            end
         end
         PH_DONE: begin
            emit = (ch == CH_NUL);
         end
         default: begin
            if (ch == CH_NUL) begin
               n_err = 1'b1;
               emit  = 1'b1;
            end
         end
      endcase

      if (n_err)      out_value_in = '0;
      else if (n_neg) out_value_in = ACC_W'(0) - n_acc;
      else            out_value_in = n_acc;

      // a terminator starts the next number from the reset state
      if (emit) begin
         neg_in  = 1'b0;
         acc_in  = '0;
         sfx_in  = SFX_NONE;
         err_in  = 1'b0;
         wrap_in = 1'b0;
      end else begin
         neg_in  = n_neg;
         acc_in  = n_acc;
         sfx_in  = n_sfx;
         err_in  = n_err;
         wrap_in = n_wrap;
      end

      out_err_in  = n_err;
      out_wrap_in = n_wrap;
   end

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         sfx_ff       <= SFX_NONE;
         err_ff       <= 1'b0;
         wrap_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         if (advance) begin
            neg_ff  <= neg_in;
            acc_ff  <= acc_in;
            sfx_ff  <= sfx_in;
            err_ff  <= err_in;
            wrap_ff <= wrap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (advance && emit) begin
         out_value_ff <= out_value_in;
         out_err_ff   <= out_err_in;
         out_wrap_ff  <= out_wrap_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = signed'(out_value_ff);
   assign rsp_malformed = out_err_ff;
   assign rsp_wrapped   = out_wrap_ff;

endmodule

// ===== design/nlp_checker.sv =====
// port-level checker for the number literal parser and its bind
module nlp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [63:0] rsp_value,
   input logic               rsp_malformed,
   input logic               rsp_wrapped
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
         && $stable(rsp_malformed) && $stable(rsp_wrapped))
      else $error("result item changed while stalled");

   // malformed literals always read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_value == 64'sd0)
      else $error("malformed item with nonzero value");

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result follows an accepted item, through the input and result registers
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result item without an accepted terminator");

endmodule

bind number_literal_parser_with_size_suffix_unit nlp_checker u_nlp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_value     (rsp_value),
   .rsp_malformed (rsp_malformed),
   .rsp_wrapped   (rsp_wrapped)
);
